[hw/rtl/fmt_pkg.sv]
// fault maturity tracker package: field widths, mode and register codes,
// the carry word passed along the cell chain and the saturating adder
// no dependencies
package fmt_pkg;

	localparam int NUM_FAULTS_DEF = 16;

	localparam int MODE_W  = 2;
	localparam int CODE_W  = 8;
	localparam int DELTA_W = 16;
	localparam int TIMER_W = 32;
	localparam int OCC_W   = 16;
	localparam int CFG_IDX_W = 1;

	// item modes
	localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REPORT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MATURITY_THR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_THR = 1'd1;

	// word handed from cell to cell: the item plus the gathered result
	typedef struct packed {
		logic               vld;
		logic [MODE_W-1:0]  mode;
		logic [CODE_W-1:0]  code;
		logic [DELTA_W-1:0] delta;
		logic               hit;
		logic               act;
		logic [TIMER_W-1:0] mat;
		logic [TIMER_W-1:0] rec;
		logic [OCC_W-1:0]   occ;
		logic               any;
	} fmt_carry_t;

	// timer plus elapsed time, saturating at all ones
	function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] a,
			input logic [DELTA_W-1:0] d);
		logic [TIMER_W:0] s;
		s = {1'b0, a} + {{(TIMER_W+1-DELTA_W){1'b0}}, d};
		return s[TIMER_W] ? {TIMER_W{1'b1}} : s[TIMER_W-1:0];
	endfunction

endpackage

[hw/rtl/fault_maturity_tracker_unit.sv]
// fault maturity tracker: one item per cycle sustained while the output is
// taken; each item walks the chain of NUM_FAULTS entry cells, one cell per
// cycle while the chain moves, from accepted item to result. the whole
// chain holds while a result waits at the output.
// reset clears every entry, both thresholds and all valid bits.
// depends on fmt_pkg and fmt_cell
module fault_maturity_tracker_unit import fmt_pkg::*; #(
	parameter int NUM_FAULTS = NUM_FAULTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [MODE_W-1:0]    mode,
	input  logic [CODE_W-1:0]    fault_id,
	input  logic [DELTA_W-1:0]   elapsed_ms,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 code_valid,
	output logic                 active,
	output logic [TIMER_W-1:0]   active_span_ms,
	output logic [TIMER_W-1:0]   recovery_ms,
	output logic [OCC_W-1:0]     occurrences,
	output logic                 mature,
	output logic                 recovered,
	output logic                 any_active,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIMER_W-1:0]   cfg_data
);

	logic [TIMER_W-1:0] mat_thr_q;
	logic [TIMER_W-1:0] rec_thr_q;
	logic               adv;
	fmt_carry_t         chain [NUM_FAULTS+1];
	fmt_carry_t         last;

	// threshold registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_thr_q <= '0;
			rec_thr_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MATURITY_THR: mat_thr_q <= cfg_data;
				REG_RECOVERY_THR: rec_thr_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// chain moves whenever the output slot is free or being taken
	assign adv      = !last.vld || out_ready;
	assign in_ready = adv;

	// item entering the chain
	always_comb begin
		chain[0].vld   = in_valid;
		chain[0].mode  = mode;
		chain[0].code  = fault_id;
		chain[0].delta = elapsed_ms;
		chain[0].hit   = (fault_id != '0) && (32'(fault_id) < 32'(NUM_FAULTS));
		chain[0].act   = 1'b0;
		chain[0].mat   = '0;
		chain[0].rec   = '0;
		chain[0].occ   = '0;
		chain[0].any   = 1'b0;
	end

	// row of entry cells
	for (genvar i = 0; i < NUM_FAULTS; i++) begin : g_cell
		fmt_cell #(
			.IDX(i)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (adv),
			.c_in  (chain[i]),
			.c_out (chain[i+1])
		);
	end

	assign last = chain[NUM_FAULTS];

	// result from the end of the chain
	assign out_valid      = last.vld;
	assign code_valid     = last.hit;
	assign active         = last.act;
	assign active_span_ms = last.mat;
	assign recovery_ms    = last.rec;
	assign occurrences    = last.occ;
	assign mature         = last.act && (last.mat >= mat_thr_q);
	assign recovered      = last.hit && !last.act && (last.rec >= rec_thr_q);
	assign any_active     = last.any;

	// invalid codes report an empty entry
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !code_valid |-> !active && active_span_ms == '0 &&
			recovery_ms == '0 && occurrences == '0 && !recovered)
		else $error("invalid code with nonzero status");

	// the addressed fault being active implies the table has an active fault
	a_any_covers: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && active |-> any_active)
		else $error("active fault without any_active");

	// a fault is never mature and recovered at once
	a_verdicts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(mature && recovered))
		else $error("mature and recovered together");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(active_span_ms) && $stable(active))
		else $error("result changed while stalled");

endmodule

[hw/rtl/fmt_cell.sv]
// fault maturity tracker cell: holds one fault entry, applies the passing
// item to it and merges its status into the carry for the next cell
// depends on fmt_pkg
module fmt_cell import fmt_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  fmt_carry_t c_in,
	output fmt_carry_t c_out
);

	localparam logic [CODE_W-1:0] IDX_CODE = CODE_W'(IDX);

	logic               act_q, act_n;
	logic [TIMER_W-1:0] mat_q, mat_n;
	logic [TIMER_W-1:0] rec_q, rec_n;
	logic [OCC_W-1:0]   occ_q, occ_n;
	logic               own;
	fmt_carry_t         carry_q;

	assign own = c_in.hit && (c_in.code == IDX_CODE);

	// next entry state for the passing item
	always_comb begin
		act_n = act_q;
		mat_n = mat_q;
		rec_n = rec_q;
		occ_n = occ_q;
		case (c_in.mode)
			MODE_TICK: begin
				if (act_q) begin
					mat_n = sat_add(mat_q, c_in.delta);
				end else if (rec_q != '0 || occ_q != '0) begin
					rec_n = sat_add(rec_q, c_in.delta);
				end
			end
			MODE_REPORT: begin
				if (own) begin
					if (!act_q) begin
						if (occ_q != {OCC_W{1'b1}})
							occ_n = occ_q + OCC_W'(1);
						rec_n = '0;
					end
					act_n = 1'b1;
				end
			end
			MODE_CLEAR: begin
				if (own) begin
					act_n = 1'b0;
					mat_n = '0;
				end
			end
			default: begin
			end
		endcase
	end

	// entry state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			mat_q <= '0;
			rec_q <= '0;
			occ_q <= '0;
		end else if (en && c_in.vld) begin
			act_q <= act_n;
			mat_q <= mat_n;
			rec_q <= rec_n;
			occ_q <= occ_n;
		end
	end

	// carry to the next cell, addressed cell drops its status in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
		end else if (en) begin
			carry_q.vld   <= c_in.vld;
			carry_q.mode  <= c_in.mode;
			carry_q.code  <= c_in.code;
			carry_q.delta <= c_in.delta;
			carry_q.hit   <= c_in.hit;
			carry_q.act   <= own ? act_n : c_in.act;
			carry_q.mat   <= own ? mat_n : c_in.mat;
			carry_q.rec   <= own ? rec_n : c_in.rec;
			carry_q.occ   <= own ? occ_n : c_in.occ;
			carry_q.any   <= c_in.any | act_n;
		end
	end

	assign c_out = carry_q;

	// a report leaves the entry active
	a_report_sets: assert property (@(posedge clk) disable iff (!arst_n)
		en && c_in.vld && own && c_in.mode == MODE_REPORT |=> act_q)
		else $error("reported fault not active");

	// a clear leaves the entry inactive with its maturity timer at zero
	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		en && c_in.vld && own && c_in.mode == MODE_CLEAR |=> !act_q && mat_q == '0)
		else $error("cleared fault not reset");

	// an active entry has occurred at least once
	a_active_counted: assert property (@(posedge clk) disable iff (!arst_n)
		act_q |-> occ_q != '0)
		else $error("active fault with zero occurrences");

endmodule

[bench/fault_maturity_tracker_unit_tb.sv]
// testbench for fault_maturity_tracker_unit: directed table, full-rate run and
// random phases, results checked against typed rows or a fault table tracked alongside
// depends on fmt_pkg and fault_maturity_tracker_unit
`timescale 1ns / 100ps

module fault_maturity_tracker_unit_tb;
	import fmt_pkg::*;

	localparam int NF             = NUM_FAULTS_DEF;
	localparam int RAND_ITEMS     = 310;
	localparam int SAT_ROUNDS     = 40;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int MAX_PRINTS     = 60;

	// mode with no defined action, only returns the status
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic               code_valid;
		logic               active;
		logic [TIMER_W-1:0] active_span_ms;
		logic [TIMER_W-1:0] recovery_ms;
		logic [OCC_W-1:0]   occurrences;
		logic               mature;
		logic               recovered;
		logic               any_active;
	} status_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [CODE_W-1:0]  code;
		logic [DELTA_W-1:0] delta;
		logic               typed;
		status_t            want;
	} row_t;

	localparam int NUM_ROWS = 24;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_ready;
	logic [MODE_W-1:0] mode;
	logic [CODE_W-1:0] fault_id;
	logic [DELTA_W-1:0] elapsed_ms;
	logic out_valid, out_ready;
	logic code_valid, active, mature, recovered, any_active;
	logic [TIMER_W-1:0] active_span_ms, recovery_ms;
	logic [OCC_W-1:0] occurrences;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TIMER_W-1:0] cfg_data;

	// tracked copy of the fault table and thresholds
	logic               fault_on  [NF];
	logic [TIMER_W-1:0] active_ms [NF];
	logic [TIMER_W-1:0] idle_ms   [NF];
	logic [OCC_W-1:0]   occ_count [NF];
	logic [TIMER_W-1:0] mature_after;
	logic [TIMER_W-1:0] recover_after;

	status_t status_due [$];
	status_t seen_status;
	status_t due_status;
	int unsigned errors = 0;
	int unsigned results_seen = 0;
	int unsigned quiet_cycles = 0;
	bit idle_en = 1'b1;
	bit hold_req = 1'b0;

	row_t directed_rows [NUM_ROWS] = '{
		'{MODE_TICK,    0,     0,     1, '{0, 0, 0,     0,     0, 0, 0, 0}},
		'{MODE_REPORT,  0,     0,     1, '{0, 0, 0,     0,     0, 0, 0, 0}},
		'{MODE_REPORT,  255,   0,     1, '{0, 0, 0,     0,     0, 0, 0, 0}},
		'{MODE_REPORT,  16,    0,     1, '{0, 0, 0,     0,     0, 0, 0, 0}},
		'{MODE_CLEAR,   200,   0,     1, '{0, 0, 0,     0,     0, 0, 0, 0}},
		'{MODE_UNUSED,  1,     65535, 1, '{1, 0, 0,     0,     0, 0, 1, 0}},
		'{MODE_REPORT,  1,     0,     1, '{1, 1, 0,     0,     1, 1, 0, 1}},
		'{MODE_REPORT,  15,    0,     1, '{1, 1, 0,     0,     1, 1, 0, 1}},
		'{MODE_TICK,    0,     65535, 1, '{0, 0, 0,     0,     0, 0, 0, 1}},
		'{MODE_UNUSED,  1,     0,     1, '{1, 1, 65535, 0,     1, 1, 0, 1}},
		'{MODE_REPORT,  1,     0,     1, '{1, 1, 65535, 0,     1, 1, 0, 1}},
		'{MODE_CLEAR,   1,     0,     1, '{1, 0, 0,     0,     1, 0, 1, 1}},
		'{MODE_TICK,    1,     32768, 1, '{1, 0, 0,     32768, 1, 0, 1, 1}},
		'{MODE_TICK,    15,    21845, 0, '0},
		'{MODE_TICK,    170,   43690, 0, '0},
		'{MODE_CLEAR,   15,    0,     0, '0},
		'{MODE_UNUSED,  2,     0,     1, '{1, 0, 0,     0,     0, 0, 1, 0}},
		'{MODE_TICK,    2,     100,   1, '{1, 0, 0,     0,     0, 0, 1, 0}},
		'{MODE_REPORT,  1,     0,     0, '0},
		'{MODE_CLEAR,   85,    0,     0, '0},
		'{MODE_UNUSED,  0,     0,     0, '0},
		'{MODE_CLEAR,   1,     0,     0, '0},
		'{MODE_CLEAR,   1,     0,     0, '0},
		'{MODE_REPORT,  14,    12345, 0, '0}
	};

	fault_maturity_tracker_unit #(
		.NUM_FAULTS(NF)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.fault_id      (fault_id),
		.elapsed_ms    (elapsed_ms),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.code_valid    (code_valid),
		.active        (active),
		.active_span_ms(active_span_ms),
		.recovery_ms   (recovery_ms),
		.occurrences   (occurrences),
		.mature        (mature),
		.recovered     (recovered),
		.any_active    (any_active),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// timer advance, pinned at all ones
	function automatic logic [TIMER_W-1:0] timer_plus(input logic [TIMER_W-1:0] t,
			input logic [DELTA_W-1:0] d);
		logic [TIMER_W:0] wide;
		wide = {1'b0, t} + {{(TIMER_W+1-DELTA_W){1'b0}}, d};
		if (wide > {1'b0, {TIMER_W{1'b1}}})
			return {TIMER_W{1'b1}};
		return wide[TIMER_W-1:0];
	endfunction

	// apply one item to the tracked table and return the addressed fault's status
	function automatic status_t track_fault(input logic [MODE_W-1:0] m,
			input logic [CODE_W-1:0] c, input logic [DELTA_W-1:0] d);
		status_t s;
		logic hit;
		s = '0;
		hit = (c != 0) && (c < NF);
		case (m)
			MODE_TICK: begin
				for (int i = 0; i < NF; i++) begin
					if (fault_on[i])
						active_ms[i] = timer_plus(active_ms[i], d);
					else if (idle_ms[i] != 0 || occ_count[i] != 0)
						idle_ms[i] = timer_plus(idle_ms[i], d);
				end
			end
			MODE_REPORT: begin
				if (hit && !fault_on[c]) begin
					if (occ_count[c] != {OCC_W{1'b1}})
						occ_count[c] = occ_count[c] + 1'b1;
					idle_ms[c] = '0;
				end
				if (hit)
					fault_on[c] = 1'b1;
			end
			MODE_CLEAR: begin
				if (hit) begin
					fault_on[c] = 1'b0;
					active_ms[c] = '0;
				end
			end
			default: ;
		endcase
		for (int i = 0; i < NF; i++)
			if (fault_on[i])
				s.any_active = 1'b1;
		if (hit) begin
			s.code_valid     = 1'b1;
			s.active         = fault_on[c];
			s.active_span_ms = active_ms[c];
			s.recovery_ms    = idle_ms[c];
			s.occurrences    = occ_count[c];
			s.mature         = fault_on[c] && (active_ms[c] >= mature_after);
			s.recovered      = !fault_on[c] && (idle_ms[c] >= recover_after);
		end
		return s;
	endfunction

	// gap length: mostly none or short, now and then long
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic flag_error(input string what);
		errors++;
		// keep the log short
		if (errors <= MAX_PRINTS)
			$display("%0t ns: result %0d: %s", $time, results_seen, what);
	endtask

	task automatic check_field(input string name, input logic [TIMER_W-1:0] got,
			input logic [TIMER_W-1:0] want);
		if (got !== want)
			flag_error($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	// offer one item, wait for the handshake, then queue its expected status
	task automatic offer_item(input logic [MODE_W-1:0] m, input logic [CODE_W-1:0] c,
			input logic [DELTA_W-1:0] d, input logic typed, input status_t typed_want);
		int unsigned gap;
		status_t predicted;
		gap = idle_en ? idle_len() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= m;
		fault_id   <= c;
		elapsed_ms <= d;
		do @(posedge clk); while (!in_ready);
		predicted = track_fault(m, c, d);
		status_due.push_back(typed ? typed_want : predicted);
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (status_due.size() != 0)
			@(posedge clk);
	endtask

	// write both thresholds back to back, block idle
	task automatic write_thresholds(input logic [TIMER_W-1:0] mat,
			input logic [TIMER_W-1:0] rec);
		cfg_valid <= 1'b1;
		cfg_index <= REG_MATURITY_THR;
		cfg_data  <= mat;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_RECOVERY_THR;
		cfg_data  <= rec;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		mature_after  = mat;
		recover_after = rec;
		@(posedge clk);
	endtask

	// receiver: random stalls, one long hold-off on request
	initial begin
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_en && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat (idle_len() + 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_status = '{code_valid, active, active_span_ms, recovery_ms, occurrences,
				mature, recovered, any_active};
			if (status_due.size() == 0) begin
				flag_error("result with nothing expected");
			end else begin
				due_status = status_due.pop_front();
				check_field("code_valid", seen_status.code_valid, due_status.code_valid);
				check_field("active", seen_status.active, due_status.active);
				check_field("active_span_ms", seen_status.active_span_ms,
					due_status.active_span_ms);
				check_field("recovery_ms", seen_status.recovery_ms, due_status.recovery_ms);
				check_field("occurrences", seen_status.occurrences, due_status.occurrences);
				check_field("mature", seen_status.mature, due_status.mature);
				check_field("recovered", seen_status.recovered, due_status.recovered);
				check_field("any_active", seen_status.any_active, due_status.any_active);
			end
			results_seen++;
		end
	end

	// watchdog on cycles where no channel moves
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("fault_maturity_tracker_unit_tb: FAIL");
			$finish;
		end
	end

	// stimulus
	initial begin
		int unsigned r;
		logic [MODE_W-1:0] m;
		logic [CODE_W-1:0] c;
		logic [DELTA_W-1:0] d;
		logic [TIMER_W-1:0] mat_thr, rec_thr;

		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		mode       <= MODE_TICK;
		fault_id   <= '0;
		elapsed_ms <= '0;
		cfg_valid  <= 1'b0;
		cfg_index  <= REG_MATURITY_THR;
		cfg_data   <= '0;
		for (int i = 0; i < NF; i++) begin
			fault_on[i]  = 1'b0;
			active_ms[i] = '0;
			idle_ms[i]   = '0;
			occ_count[i] = '0;
		end
		mature_after  = '0;
		recover_after = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at zero thresholds
		write_thresholds('0, '0);
		for (int k = 0; k < NUM_ROWS; k++)
			offer_item(directed_rows[k].mode, directed_rows[k].code, directed_rows[k].delta,
				directed_rows[k].typed, directed_rows[k].want);
		drain();

		// full-rate run: report, clear and large ticks back to back
		write_thresholds('1, '1);
		idle_en = 1'b0;
		offer_item(MODE_REPORT, 5, 0, 1'b0, '0);
		for (int k = 0; k < SAT_ROUNDS; k++) begin
			offer_item(MODE_REPORT, 7, 0, 1'b0, '0);
			offer_item(MODE_CLEAR, 7, 0, 1'b0, '0);
			offer_item(MODE_TICK, 5, '1, 1'b0, '0);
		end
		for (int k = 1; k < NF; k++)
			offer_item(MODE_UNUSED, CODE_W'(k), '0, 1'b0, '0);
		drain();

		// random phases, each with its own threshold pair
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin mat_thr = 2000;     rec_thr = 3000; end
				1: begin mat_thr = '0;       rec_thr = '1;   end
				2: begin mat_thr = '1;       rec_thr = '0;   end
				default: begin
					mat_thr = $urandom_range(0, 200000);
					rec_thr = $urandom_range(0, 200000);
				end
			endcase
			write_thresholds(mat_thr, rec_thr);
			for (int n = 0; n < RAND_ITEMS; n++) begin
				if (n % 100 == 0)
					idle_en = ($urandom_range(0, 3) != 0);
				// long receiver hold-off while items keep coming
				if (ph == 0 && n == 120)
					hold_req = 1'b1;
				r = $urandom_range(0, 99);
				if (r < 40)
					m = MODE_TICK;
				else if (r < 70)
					m = MODE_REPORT;
				else if (r < 92)
					m = MODE_CLEAR;
				else
					m = MODE_UNUSED;
				r = $urandom_range(0, 99);
				if (r < 70)
					c = CODE_W'($urandom_range(1, 4));
				else if (r < 82)
					c = CODE_W'($urandom_range(1, NF - 1));
				else if (r < 91)
					c = '0;
				else
					c = CODE_W'($urandom_range(NF, 255));
				r = $urandom_range(0, 99);
				if (r < 40)
					d = 16'(100 * $urandom_range(0, 10));
				else if (r < 70)
					d = DELTA_W'($urandom_range(0, 65535));
				else if (r < 85)
					d = '1;
				else
					d = '0;
				offer_item(m, c, d, 1'b0, '0);
			end
			drain();
		end

		// let any stray result show up
		idle_en = 1'b0;
		repeat (2 * NF) @(posedge clk);
		if (status_due.size() != 0)
			flag_error("results still outstanding");
		if (errors == 0)
			$display("fault_maturity_tracker_unit_tb: PASS");
		else
			$display("fault_maturity_tracker_unit_tb: FAIL");
		$finish;
	end

endmodule
